[rtl/deq_pkg.sv]
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // fixed field widths of the request and response
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 5;

   typedef enum logic [2:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_PEEK_FRONT = 3'd4,
      KIND_PEEK_BACK  = 3'd5,
      KIND_CONTAINS   = 3'd6,
      KIND_CLEAR      = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   value_in;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   value_out;
      logic                 found;
      status_type           status;
      logic [COUNT_W-1:0]   count;
   } rsp_type;

   // broadcast shift control for the cell row
   typedef struct packed {
      logic take_left;    // move every entry one cell toward the back
      logic take_right;   // move every entry one cell toward the front
   } cell_ctrl_type;

endpackage

[rtl/deq_cell.sv]
module deq_cell (
   input  logic                               clock,
   input  deq_pkg::cell_ctrl_type             ctrl,
   input  logic                               write_en,
   input  logic [deq_pkg::DATA_WIDTH-1:0]     new_data,
   input  logic [deq_pkg::DATA_WIDTH-1:0]     left_data,
   input  logic [deq_pkg::DATA_WIDTH-1:0]     right_data,
   output logic [deq_pkg::DATA_WIDTH-1:0]     data_out,
   output logic                               match
);

   logic [deq_pkg::DATA_WIDTH-1:0] data_ff;
   logic [deq_pkg::DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (write_en) begin
         data_in = new_data;
      end else if (ctrl.take_left) begin
         data_in = left_data;
      end else if (ctrl.take_right) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign match    = (data_ff == new_data);

endmodule

[rtl/double_ended_queue.sv]
// A result appears on rsp_data with rsp_strobe in the cycle after start is taken.
// Throughput: one operation per clock; busy stays low, since every operation,
// the membership search included, completes as the cell row updates.
// Reset: clears the entry count and the response strobe; cell contents are not cleared
// and are never read before they are written.
// The receiver cannot stall: each response is valid for exactly one cycle.
module double_ended_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  deq_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output deq_pkg::rsp_type  rsp_data
);

   localparam int Depth  = deq_pkg::DEPTH;
   localparam int DataW  = deq_pkg::DATA_WIDTH;
   localparam int IdxW   = deq_pkg::IDX_W;
   localparam int CntW   = deq_pkg::CNT_W;
   localparam int ValW   = deq_pkg::VALUE_W;
   localparam int CountW = deq_pkg::COUNT_W;

   // entry i of the row is the i-th entry from the front
   logic [DataW-1:0]       cell_data [Depth];
   logic [Depth-1:0]       cell_match;
   logic [Depth-1:0]       cell_write;
   logic [Depth-1:0]       cell_valid;
   deq_pkg::cell_ctrl_type cell_ctrl;

   logic [CntW-1:0]        held_ff;
   logic [CntW-1:0]        held_in;
   logic                   strobe_ff;
   deq_pkg::rsp_type       rsp_ff;
   deq_pkg::rsp_type       rsp_in;

   logic                   accept;
   logic                   is_empty;
   logic                   is_full;
   logic [DataW-1:0]       key;
   logic [IdxW-1:0]        back_index;
   logic [CntW-1:0]        back_count;

   // the block never holds off a request
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign key        = DataW'(req_data.value_in);
   assign is_empty   = (held_ff == '0);
   assign is_full    = (held_ff == CntW'(Depth));
   assign back_count = held_ff - CntW'(1);
   assign back_index = back_count[IdxW-1:0];

   // --- cell row -------------------------------------------------------
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic [DataW-1:0] left_data;
      logic [DataW-1:0] right_data;

      // the front cell takes the new value on a front push
      if (i == 0) begin : g_first
         assign left_data = key;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end

      // the back cell keeps its own data on a front pop; it is no longer held then
      if (i == Depth - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      assign cell_valid[i] = (CntW'(i) < held_ff);
      assign cell_write[i] = accept && (req_data.kind == deq_pkg::KIND_PUSH_BACK)
                             && !is_full && (held_ff == CntW'(i));

      deq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .write_en   (cell_write[i]),
         .new_data   (key),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .match      (cell_match[i])
      );
   end

   // --- operation decode -----------------------------------------------
   always_comb begin
      cell_ctrl       = '0;
      held_in         = held_ff;
      rsp_in          = '0;
      rsp_in.status   = deq_pkg::STATUS_OK;

      if (accept) begin
         unique case (req_data.kind)
            deq_pkg::KIND_PUSH_BACK: begin
               // the cell at the back slot loads itself
               if (is_full) begin
                  rsp_in.status = deq_pkg::STATUS_FULL;
               end else begin
                  held_in = held_ff + CntW'(1);
               end
            end
            deq_pkg::KIND_PUSH_FRONT: begin
               // shift everything one cell back, new value enters at the front
               if (is_full) begin
                  rsp_in.status = deq_pkg::STATUS_FULL;
               end else begin
                  cell_ctrl.take_left = 1'b1;
                  held_in             = held_ff + CntW'(1);
               end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
               if (is_empty) begin
                  rsp_in.status = deq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_in.value_out = ValW'(cell_data[0]);
                  if (req_data.kind == deq_pkg::KIND_POP_FRONT) begin
                     cell_ctrl.take_right = 1'b1;
                     held_in              = back_count;
                  end
               end
            end
            deq_pkg::KIND_POP_BACK, deq_pkg::KIND_PEEK_BACK: begin
               // drop the back entry by shrinking the count; no data moves
               if (is_empty) begin
                  rsp_in.status = deq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_in.value_out = ValW'(cell_data[back_index]);
                  if (req_data.kind == deq_pkg::KIND_POP_BACK) begin
                     held_in = back_count;
                  end
               end
            end
            deq_pkg::KIND_CONTAINS: begin
               // every held cell compares against the key at once
               rsp_in.found = |(cell_match & cell_valid);
            end
            deq_pkg::KIND_CLEAR: begin
               held_in = '0;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end

      rsp_in.count = CountW'(held_in);
   end

   // --- state and response registers -----------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         held_ff   <= held_in;
         strobe_ff <= accept;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // --- assertions -----------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      held_ff <= CntW'(Depth))
      else $error("entry count above depth");

   a_one_rsp_per_transfer : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("transfer without a response");

   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without a transfer");

   a_full_push_drops : assert property (@(posedge clock) disable iff (reset)
      accept && is_full && (req_data.kind == deq_pkg::KIND_PUSH_BACK ||
                            req_data.kind == deq_pkg::KIND_PUSH_FRONT)
      |=> rsp_data.status == deq_pkg::STATUS_FULL && held_ff == CntW'(Depth))
      else $error("push while full changed the queue");

   a_found_only_on_search : assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind != deq_pkg::KIND_CONTAINS |=> !rsp_data.found)
      else $error("found flag outside a membership test");

endmodule

[verif/deque_checker.sv]
`timescale 1ns / 100ps

module deque_checker
   import deq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  req_type  req_data,
   input  logic     rsp_strobe,
   input  rsp_type  rsp_data,
   output int       fail_count,
   output int       outstanding
);

   // Shadow copy of the deque contents
   logic [DATA_WIDTH-1:0] cells [DEPTH];
   int                    head_slot = 0;
   int                    held = 0;

   rsp_type pending_results [$];
   int      failures = 0;
   int      waiting = 0;

   assign fail_count  = failures;
   assign outstanding = waiting;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      failures++;
   endtask

   // Compute the response of one operation and advance the shadow state.
   task automatic predict_deque_op(input req_type op, output rsp_type res);
      int slot;
      res = '0;
      res.status = STATUS_OK;
      case (op.kind)
         KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
            if (held >= DEPTH) begin
               res.status = STATUS_FULL;
            end else if (op.kind == KIND_PUSH_BACK) begin
               slot = (head_slot + held) % DEPTH;
               cells[slot] = DATA_WIDTH'(op.value_in);
               held++;
            end else begin
               head_slot = (head_slot + DEPTH - 1) % DEPTH;
               cells[head_slot] = DATA_WIDTH'(op.value_in);
               held++;
            end
         end
         KIND_POP_FRONT, KIND_PEEK_FRONT: begin
            if (held == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.value_out = VALUE_W'(cells[head_slot]);
               if (op.kind == KIND_POP_FRONT) begin
                  head_slot = (head_slot + 1) % DEPTH;
                  held--;
               end
            end
         end
         KIND_POP_BACK, KIND_PEEK_BACK: begin
            if (held == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.value_out = VALUE_W'(cells[(head_slot + held - 1) % DEPTH]);
               if (op.kind == KIND_POP_BACK)
                  held--;
            end
         end
         KIND_CONTAINS: begin
            for (int i = 0; i < held; i++)
               if (cells[(head_slot + i) % DEPTH] == DATA_WIDTH'(op.value_in))
                  res.found = 1'b1;
         end
         default: begin
            held = 0;
            head_slot = 0;
         end
      endcase
      res.count = COUNT_W'(held);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         held = 0;
         head_slot = 0;
         pending_results.delete();
      end else begin
         // Queue the prediction first so a same-edge response still finds it.
         if (start && !busy) begin
            predict_deque_op(req_data, want);
            pending_results.push_back(want);
         end
         if (rsp_strobe) begin
            got = rsp_data;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing pending", got));
            end else begin
               want = pending_results.pop_front();
               if (got.value_out !== want.value_out)
                  report_mismatch($sformatf("value_out %h, want %h",
                                            got.value_out, want.value_out));
               if (got.found !== want.found)
                  report_mismatch($sformatf("found %b, want %b", got.found, want.found));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            got.status, want.status));
               if (got.count !== want.count)
                  report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
            end
         end
      end
      waiting <= pending_results.size();
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import deq_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   // Far beyond the slowest legal run of the random items and their gaps.
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;
   int      cycles = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   deque_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[double_ended_queue] ERROR");
         $finish;
      end
   end

   // Present one operation and hold it until the transfer takes place.
   task automatic send_op(input kind_type kind, input logic [VALUE_W-1:0] value);
      req_data <= '{kind: kind, value_in: value};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and hold off until the checker has seen every response.
   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      logic [VALUE_W-1:0] recent [8];
      logic [VALUE_W-1:0] value;
      kind_type           kind;
      int                 mode;
      int                 mode_left;
      int                 burst_left;
      int                 gap;
      int                 pick;

      foreach (recent[i])
         recent[i] = $urandom();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every read and search on an empty deque, then clear on empty.
      send_op(KIND_POP_FRONT,  32'h1234_5678);
      send_op(KIND_POP_BACK,   '0);
      send_op(KIND_PEEK_FRONT, '1);
      send_op(KIND_PEEK_BACK,  '0);
      send_op(KIND_CONTAINS,   '0);
      send_op(KIND_CLEAR,      '1);

      // Extreme values at both ends; the front push wraps below slot zero.
      send_op(KIND_PUSH_BACK,  '0);
      send_op(KIND_PUSH_FRONT, '1);
      send_op(KIND_PEEK_FRONT, '0);
      send_op(KIND_PEEK_BACK,  '1);
      send_op(KIND_CONTAINS,   '0);
      send_op(KIND_CONTAINS,   32'h0000_0005);

      // Fill to capacity from alternating ends, then push into a full deque.
      for (int i = 2; i < DEPTH; i++)
         send_op((i % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom());
      send_op(KIND_PUSH_BACK,  32'hDEAD_BEEF);
      send_op(KIND_PUSH_FRONT, 32'hCAFE_F00D);
      drain_responses();

      // Random part: phases that favor filling, draining or a mix, so the
      // deque swings between empty and full while pointers wrap.
      mode       = 0;
      mode_left  = 0;
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (mode_left == 0) begin
            mode      = $urandom_range(2);
            mode_left = $urandom_range(10, 50);
         end
         mode_left--;

         pick = $urandom_range(99);
         if (pick < 2)
            kind = KIND_CLEAR;
         else if ((mode == 0 && pick < 70) || (mode == 2 && pick < 40))
            kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
         else if ((mode == 1 && pick < 70) || (mode == 2 && pick < 70))
            kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
         else
            kind = kind_type'($urandom_range(KIND_PEEK_FRONT, KIND_CONTAINS));

         // Reuse recent values so searches hit and duplicates are held.
         pick = $urandom_range(9);
         if (pick < 4 && kind == KIND_CONTAINS)
            value = recent[$urandom_range(7)];
         else if (pick == 0)
            value = recent[$urandom_range(7)];
         else if (pick == 1)
            value = $urandom_range(1) ? '0 : '1;
         else
            value = $urandom();
         if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT)
            recent[$urandom_range(7)] = value;

         send_op(kind, value);

         // Advance the burst; a quarter of the bursts run straight on.
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (n % 400 == 399)
            drain_responses();
      end

      drain_responses();
      repeat (4) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("[double_ended_queue] OK");
      end else begin
         $display("[double_ended_queue] ERROR");
      end
      $finish;
   end

endmodule
